### sv/spap_pkg.sv
package spap_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int TIME_FRAC_BITS = 16;

  localparam int INC_W      = 24;
  localparam int TIME_W     = 32;
  localparam int DIST_W     = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam int ANGLE_SHIFT = 16 + TIME_FRAC_BITS;
  localparam int QUAD_SHIFT  = 2 * TIME_FRAC_BITS + 16;
  localparam int COS_SHIFT   = 16;

  // quarter-wave table: entries 0..COS_QTR inclusive
  localparam int COS_STEP_SHIFT = 16 - COS_TABLE_BITS;
  localparam int COS_QTR        = 1 << (COS_TABLE_BITS - 2);
  localparam int COS_ROM_DEPTH  = COS_QTR + 1;
  localparam int COS_ADDR_W     = COS_TABLE_BITS - 1;
  localparam int COS_ENTRY_W    = 17;
  localparam int OMC_W          = 18;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_END    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECEL_BEGIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_DUR     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_LEN     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_ACCEL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OMEGA  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OMEGA_RATE   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_VEL   = 3'd7;

  // sequencer steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] ST_TIME    = 4'd1;
  localparam logic [PC_W-1:0] ST_PHASE   = 4'd2;
  localparam logic [PC_W-1:0] ST_ANG     = 4'd3;
  localparam logic [PC_W-1:0] ST_SQ      = 4'd4;
  localparam logic [PC_W-1:0] ST_QLO     = 4'd5;
  localparam logic [PC_W-1:0] ST_QHI     = 4'd6;
  localparam logic [PC_W-1:0] ST_CLO     = 4'd7;
  localparam logic [PC_W-1:0] ST_CHI     = 4'd8;
  localparam logic [PC_W-1:0] ST_COS     = 4'd9;
  localparam logic [PC_W-1:0] ST_MIX     = 4'd10;
  localparam logic [PC_W-1:0] ST_CRZ_MUL = 4'd11;
  localparam logic [PC_W-1:0] ST_CRZ_ADD = 4'd12;
  localparam logic [PC_W-1:0] ST_EMIT    = 4'd13;

  // multiplier operand A
  localparam logic [2:0] A_TAU     = 3'd0;
  localparam logic [2:0] A_PLO     = 3'd1;
  localparam logic [2:0] A_TTHI    = 3'd2;
  localparam logic [2:0] A_AOOS_LO = 3'd3;
  localparam logic [2:0] A_AOOS_HI = 3'd4;
  localparam logic [2:0] A_INC     = 3'd5;

  // multiplier operand B
  localparam logic [2:0] B_TAU    = 3'd0;
  localparam logic [2:0] B_OMEGA  = 3'd1;
  localparam logic [2:0] B_HALF   = 3'd2;
  localparam logic [2:0] B_OMC    = 3'd3;
  localparam logic [2:0] B_CRUISE = 3'd4;

  // datapath write-back
  localparam logic [3:0] D_NONE   = 4'd0;
  localparam logic [3:0] D_TIME   = 4'd1;
  localparam logic [3:0] D_PHASE  = 4'd2;
  localparam logic [3:0] D_ANGLE  = 4'd3;
  localparam logic [3:0] D_TT     = 4'd4;
  localparam logic [3:0] D_ACC    = 4'd5;
  localparam logic [3:0] D_QUAD   = 4'd6;
  localparam logic [3:0] D_COSV   = 4'd7;
  localparam logic [3:0] D_MIX    = 4'd8;
  localparam logic [3:0] D_CRUISE = 4'd9;
  localparam logic [3:0] D_EMIT   = 4'd10;

  // next-step control
  localparam logic [2:0] J_NEXT      = 3'd0;
  localparam logic [2:0] J_WAIT_IN   = 3'd1;
  localparam logic [2:0] J_IF_CRUISE = 3'd2;
  localparam logic [2:0] J_GOTO      = 3'd3;
  localparam logic [2:0] J_WAIT_OUT  = 3'd4;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [3:0] dst;
  } ctrl_t;

  typedef struct packed {
    ctrl_t           ctrl;
    logic [2:0]      jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic cruise;
    logic out_busy;
  } status_t;

  typedef logic [COS_ENTRY_W-1:0] cos_rom_t [COS_ROM_DEPTH];

  function automatic uword_t ucode(input logic [PC_W-1:0] step);
    uword_t w;
    w.ctrl.a_sel = A_TAU;
    w.ctrl.b_sel = B_TAU;
    w.ctrl.dst   = D_NONE;
    w.jmp        = J_NEXT;
    w.target     = ST_IDLE;
    unique case (step)
      ST_IDLE:    w.jmp = J_WAIT_IN;
      ST_TIME:    w.ctrl.dst = D_TIME;
      ST_PHASE: begin
        w.ctrl.dst = D_PHASE;
        w.jmp      = J_IF_CRUISE;
        w.target   = ST_CRZ_MUL;
      end
      ST_ANG: begin
        w.ctrl.a_sel = A_TAU;
        w.ctrl.b_sel = B_OMEGA;
      end
      ST_SQ: begin
        w.ctrl.a_sel = A_TAU;
        w.ctrl.b_sel = B_TAU;
        w.ctrl.dst   = D_ANGLE;
      end
      ST_QLO: begin
        w.ctrl.a_sel = A_PLO;
        w.ctrl.b_sel = B_HALF;
        w.ctrl.dst   = D_TT;
      end
      ST_QHI: begin
        w.ctrl.a_sel = A_TTHI;
        w.ctrl.b_sel = B_HALF;
        w.ctrl.dst   = D_ACC;
      end
      ST_CLO: begin
        w.ctrl.a_sel = A_AOOS_LO;
        w.ctrl.b_sel = B_OMC;
        w.ctrl.dst   = D_QUAD;
      end
      ST_CHI: begin
        w.ctrl.a_sel = A_AOOS_HI;
        w.ctrl.b_sel = B_OMC;
        w.ctrl.dst   = D_ACC;
      end
      ST_COS:     w.ctrl.dst = D_COSV;
      ST_MIX: begin
        w.ctrl.dst = D_MIX;
        w.jmp      = J_GOTO;
        w.target   = ST_EMIT;
      end
      ST_CRZ_MUL: begin
        w.ctrl.a_sel = A_INC;
        w.ctrl.b_sel = B_CRUISE;
      end
      ST_CRZ_ADD: w.ctrl.dst = D_CRUISE;
      ST_EMIT: begin
        w.ctrl.dst = D_EMIT;
        w.jmp      = J_WAIT_OUT;
        w.target   = ST_IDLE;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // cos over a quarter turn (16384 units), Q30, Taylor series in Horner form
  function automatic longint quarter_cos(input longint u);
    longint x;
    longint x2;
    longint t;
    x  = (u * HALF_PI_Q30) >>> 14;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE - x2 / 90;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
    if (t < 0) t = 0;
    if (t > Q30_ONE) t = Q30_ONE;
    return t;
  endfunction

  // rounded Q16 cos magnitude for each quarter-wave point
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint   r;
    for (int k = 0; k < COS_ROM_DEPTH; k++) begin
      r = (quarter_cos(longint'(k) << COS_STEP_SHIFT) + 8192) >>> 14;
      rom[k] = r[COS_ENTRY_W-1:0];
    end
    return rom;
  endfunction

  function automatic logic [DIST_W-1:0] sat48(input logic signed [DIST_W+1:0] v);
    logic [DIST_W-1:0] r;
    if (v[DIST_W+1:DIST_W-1] == 3'b000 || v[DIST_W+1:DIST_W-1] == 3'b111) begin
      r = v[DIST_W-1:0];
    end else if (v[DIST_W+1]) begin
      r = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DIST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### sv/spap_tick_if.sv
interface spap_tick_if;
  logic                        valid;
  logic                        ready;
  logic [spap_pkg::INC_W-1:0]  tick_increment;
  logic                        restart;

  modport source (output valid, tick_increment, restart, input ready);
  modport sink   (input valid, tick_increment, restart, output ready);
endinterface

### sv/spap_pos_if.sv
interface spap_pos_if;
  logic                                valid;
  logic                                ready;
  logic signed [spap_pkg::DIST_W-1:0]  path_position;
  logic                                move_done;

  modport source (output valid, path_position, move_done, input ready);
  modport sink   (input valid, path_position, move_done, output ready);
endinterface

### sv/spap_useq.sv
module spap_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  spap_pkg::status_t status,
  output spap_pkg::ctrl_t   ctrl,
  output logic              in_ready
);

  logic [spap_pkg::PC_W-1:0] pc;
  logic [spap_pkg::PC_W-1:0] pc_next;
  spap_pkg::uword_t          word;

  assign word     = spap_pkg::ucode(pc);
  assign ctrl     = word.ctrl;
  assign in_ready = (pc == spap_pkg::ST_IDLE);

  always_comb begin
    unique case (word.jmp)
      spap_pkg::J_NEXT:      pc_next = pc + 4'd1;
      spap_pkg::J_WAIT_IN:   pc_next = in_valid ? pc + 4'd1 : pc;
      spap_pkg::J_IF_CRUISE: pc_next = status.cruise ? word.target : pc + 4'd1;
      spap_pkg::J_GOTO:      pc_next = word.target;
      spap_pkg::J_WAIT_OUT:  pc_next = status.out_busy ? pc : word.target;
      default:               pc_next = spap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= spap_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### sv/spap_datapath.sv
module spap_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  spap_pkg::ctrl_t                     ctrl,
  output spap_pkg::status_t                   status,
  input  logic                                accept,
  input  logic [spap_pkg::INC_W-1:0]          tick_increment,
  input  logic                                restart,
  input  logic                                cfg_we,
  input  logic [spap_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spap_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pos_ready,
  output logic                                pos_valid,
  output logic signed [spap_pkg::DIST_W-1:0]  path_position,
  output logic                                move_done
);

  localparam spap_pkg::cos_rom_t COS_ROM = spap_pkg::build_cos_rom();

  // configuration
  logic [31:0] accel_end_time;
  logic [31:0] decel_begin_time;
  logic [31:0] move_duration;
  logic [47:0] move_length;
  logic [31:0] half_accel;
  logic [47:0] accel_over_omega_sq;
  logic [31:0] omega_rate;
  logic [31:0] cruise_velocity;

  // item and state
  logic [spap_pkg::INC_W-1:0] inc;
  logic                       restart_r;
  logic [31:0]                elapsed;
  logic [47:0]                distance;
  logic                       done_r;

  // working registers
  logic [31:0] tau;
  logic [15:0] angle;
  logic [31:0] tt_hi;
  logic [63:0] p;
  logic [63:0] acc;
  logic [47:0] quad;
  logic [47:0] cosv;
  logic [spap_pkg::COS_ENTRY_W-1:0] rom_q;

  logic        in_accel;
  logic        in_cruise;
  logic [31:0] time_base;
  logic [32:0] time_sum;
  logic [31:0] a_mux;
  logic [31:0] b_mux;
  logic [63:0] prod;
  logic [63:0] part_sum;
  logic [95:0] part_tot;
  logic [95:0] quad_sh;
  logic [95:0] cos_sh;
  logic [spap_pkg::COS_ADDR_W-1:0] u_ext;
  logic [spap_pkg::COS_ADDR_W-1:0] rom_addr;
  logic [spap_pkg::OMC_W-1:0]      omc;
  logic [63:0] step_sh;
  logic signed [49:0] mix_val;
  logic signed [49:0] crz_val;
  logic        out_load;

  assign in_accel  = elapsed < accel_end_time;
  assign in_cruise = !in_accel && !(elapsed > decel_begin_time);

  assign status.cruise   = in_cruise;
  assign status.out_busy = pos_valid && !pos_ready;

  assign time_base = restart_r ? 32'd0 : elapsed;
  assign time_sum  = {1'b0, time_base} + {9'd0, inc};

  always_comb begin
    case (ctrl.a_sel)
      spap_pkg::A_TAU:     a_mux = tau;
      spap_pkg::A_PLO:     a_mux = p[31:0];
      spap_pkg::A_TTHI:    a_mux = tt_hi;
      spap_pkg::A_AOOS_LO: a_mux = accel_over_omega_sq[31:0];
      spap_pkg::A_AOOS_HI: a_mux = {16'd0, accel_over_omega_sq[47:32]};
      spap_pkg::A_INC:     a_mux = {8'd0, inc};
      default:             a_mux = tau;
    endcase
    case (ctrl.b_sel)
      spap_pkg::B_TAU:    b_mux = tau;
      spap_pkg::B_OMEGA:  b_mux = omega_rate;
      spap_pkg::B_HALF:   b_mux = half_accel;
      spap_pkg::B_OMC:    b_mux = {14'd0, omc};
      spap_pkg::B_CRUISE: b_mux = cruise_velocity;
      default:            b_mux = tau;
    endcase
  end

  assign prod = {32'd0, a_mux} * {32'd0, b_mux};

  // high partial product times 2^32 plus the low one held in acc
  assign part_sum = p + {32'd0, acc[63:32]};
  assign part_tot = {part_sum, acc[31:0]};
  assign quad_sh  = part_tot >> spap_pkg::QUAD_SHIFT;
  assign cos_sh   = part_tot >> spap_pkg::COS_SHIFT;

  // fold the angle onto the quarter-wave table; odd quadrants run mirrored
  assign u_ext    = {1'b0, angle[13:spap_pkg::COS_STEP_SHIFT]};
  assign rom_addr = angle[14] ? spap_pkg::COS_ADDR_W'(spap_pkg::COS_QTR) - u_ext : u_ext;
  // second and third quadrants have negative cos
  assign omc = (angle[15] ^ angle[14]) ? 18'd65536 + {1'b0, rom_q}
                                       : 18'd65536 - {1'b0, rom_q};

  assign step_sh = p >> spap_pkg::TIME_FRAC_BITS;

  assign mix_val = in_accel ? $signed({2'b00, quad}) - $signed({2'b00, cosv})
                            : $signed({2'b00, move_length}) - $signed({2'b00, quad})
                              + $signed({2'b00, cosv});
  assign crz_val = $signed({{2{distance[47]}}, distance}) + $signed({2'b00, step_sh[47:0]});

  assign out_load = (ctrl.dst == spap_pkg::D_EMIT) && !status.out_busy;

  always_ff @(posedge clk) begin
    rom_q <= COS_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_end_time      <= '0;
      decel_begin_time    <= '0;
      move_duration       <= '0;
      move_length         <= '0;
      half_accel          <= '0;
      accel_over_omega_sq <= '0;
      omega_rate          <= '0;
      cruise_velocity     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spap_pkg::REG_ACCEL_END:   accel_end_time      <= cfg_data[31:0];
        spap_pkg::REG_DECEL_BEGIN: decel_begin_time    <= cfg_data[31:0];
        spap_pkg::REG_MOVE_DUR:    move_duration       <= cfg_data[31:0];
        spap_pkg::REG_MOVE_LEN:    move_length         <= cfg_data[47:0];
        spap_pkg::REG_HALF_ACCEL:  half_accel          <= cfg_data[31:0];
        spap_pkg::REG_ACCEL_OMEGA: accel_over_omega_sq <= cfg_data[47:0];
        spap_pkg::REG_OMEGA_RATE:  omega_rate          <= cfg_data[31:0];
        spap_pkg::REG_CRUISE_VEL:  cruise_velocity     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    p <= prod;
    if (accept) begin
      inc       <= tick_increment;
      restart_r <= restart;
    end
    case (ctrl.dst)
      spap_pkg::D_PHASE: begin
        done_r <= elapsed > move_duration;
        if (in_accel) begin
          tau <= elapsed;
        end else if (move_duration >= elapsed) begin
          tau <= move_duration - elapsed;
        end else begin
          tau <= elapsed - move_duration;
        end
      end
      spap_pkg::D_ANGLE: angle <= p[spap_pkg::ANGLE_SHIFT+15:spap_pkg::ANGLE_SHIFT];
      spap_pkg::D_TT:    tt_hi <= p[63:32];
      spap_pkg::D_ACC:   acc   <= p;
      spap_pkg::D_QUAD:  quad  <= (|quad_sh[95:48]) ? '1 : quad_sh[47:0];
      spap_pkg::D_COSV:  cosv  <= (|cos_sh[95:48]) ? '1 : cos_sh[47:0];
      default: ;
    endcase
    if (out_load) begin
      path_position <= distance;
      move_done     <= done_r;
    end
  end

  // architectural state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      distance  <= '0;
      pos_valid <= 1'b0;
    end else begin
      case (ctrl.dst)
        spap_pkg::D_TIME: begin
          elapsed <= time_sum[32] ? '1 : time_sum[31:0];
          if (restart_r) distance <= '0;
        end
        spap_pkg::D_MIX:    distance <= spap_pkg::sat48(mix_val);
        spap_pkg::D_CRUISE: distance <= spap_pkg::sat48(crz_val);
        default: ;
      endcase
      if (out_load) begin
        pos_valid <= 1'b1;
      end else if (pos_ready) begin
        pos_valid <= 1'b0;
      end
    end
  end

  a_done_matches_time: assert property (@(posedge clk) disable iff (rst)
    out_load |=> pos_valid && (move_done == (elapsed > move_duration)))
    else $error("done flag disagrees with elapsed time");

  a_mix_not_cruise: assert property (@(posedge clk) disable iff (rst)
    (ctrl.dst == spap_pkg::D_MIX) |-> !in_cruise)
    else $error("phase terms mixed during cruise");

  a_omc_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.b_sel == spap_pkg::B_OMC) |-> (omc <= 18'd131072))
    else $error("one minus cos out of range");

endmodule

### sv/sinusoidal_accel_path_profiler.sv
// channel | dir | word                          | handshake
// tick    | in  | tick_increment[23:0], restart | valid/ready
// pos     | out | path_position[47:0] s, done   | valid/ready
// cfg     | in  | cfg_index[2:0], cfg_data[47:0]| cfg_we, no stall
//
// Accel/decel ticks run the time, phase, angle, square, quadratic, cosine,
// mix and emit steps; cruise ticks run time, phase, cruise multiply, cruise
// add and emit. The single shared 32x32 multiplier is stepped by the microcode.
// Reset clears elapsed time, distance, the configuration registers and the sequencer.
// tick.ready is high only while the sequencer idles; a result waits in the
// output register, and the sequencer holds on its last step only if the next
// result is ready before the previous word was taken.
module sinusoidal_accel_path_profiler (
  input  logic                             clk,
  input  logic                             rst,
  spap_tick_if.sink                        tick,
  spap_pos_if.source                       pos,
  input  logic                             cfg_we,
  input  logic [spap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spap_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spap_pkg::ctrl_t   ctrl;
  spap_pkg::status_t status;
  logic              in_ready;
  logic              accept;

  assign tick.ready = in_ready;
  assign accept     = tick.valid && in_ready;

  spap_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  spap_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .accept         (accept),
    .tick_increment (tick.tick_increment),
    .restart        (tick.restart),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pos_ready      (pos.ready),
    .pos_valid      (pos.valid),
    .path_position  (pos.path_position),
    .move_done      (pos.move_done)
  );

endmodule

### dv/sinusoidal_accel_path_profiler_tb.sv
module sinusoidal_accel_path_profiler_tb;
  import spap_pkg::*;

  localparam longint ONE_Q30        = 64'sd1073741824;
  localparam longint QTR_TURN_Q30   = 64'sd1686629713;
  localparam longint POS_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO         = -64'sh0000_8000_0000_0000;
  localparam longint MAX_INC        = 64'sh0000_0000_00FF_FFFF;
  localparam logic [DIST_W-1:0] MAG_MAX = {DIST_W{1'b1}};

  localparam int PROF_TYPICAL  = 0;
  localparam int PROF_RANDOM   = 1;
  localparam int PROF_MAX      = 2;
  localparam int PROF_PAST_END = 3;
  localparam int NUM_PROFILES  = 10;
  localparam int PROFILE_TICKS = 115;
  localparam int SAT_RUN_TICKS = 280;
  localparam int DRAIN_CYCLES  = 16;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [DIST_W-1:0] position;
    logic              done;
  } pos_word_t;

  class position_ledger;
    logic [TIME_W-1:0] accel_end = '0;
    logic [TIME_W-1:0] decel_begin = '0;
    logic [TIME_W-1:0] duration = '0;
    logic [DIST_W-1:0] length = '0;
    logic [TIME_W-1:0] half_acc = '0;
    logic [DIST_W-1:0] acc_omega_sq = '0;
    logic [TIME_W-1:0] omega = '0;
    logic [TIME_W-1:0] cruise = '0;
    logic [TIME_W-1:0] elapsed = '0;
    logic signed [DIST_W-1:0] distance = '0;
    pos_word_t pending_positions[$];
    int errors = 0;
    int checked = 0;

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ACCEL_END:   accel_end = val[TIME_W-1:0];
        REG_DECEL_BEGIN: decel_begin = val[TIME_W-1:0];
        REG_MOVE_DUR:    duration = val[TIME_W-1:0];
        REG_MOVE_LEN:    length = val[DIST_W-1:0];
        REG_HALF_ACCEL:  half_acc = val[TIME_W-1:0];
        REG_ACCEL_OMEGA: acc_omega_sq = val[DIST_W-1:0];
        REG_OMEGA_RATE:  omega = val[TIME_W-1:0];
        REG_CRUISE_VEL:  cruise = val[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DIST_W-1:0] scaled_product(input logic [63:0] a, input logic [31:0] b,
                                               input int sh);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> sh;
      return (p > 128'(MAG_MAX)) ? MAG_MAX : p[DIST_W-1:0];
    endfunction

    function logic [DIST_W-1:0] clamp_pos(input longint v);
      longint r;
      r = v;
      if (v > POS_HI) r = POS_HI;
      if (v < POS_LO) r = POS_LO;
      return r[DIST_W-1:0];
    endfunction

    // Q30 cosine over a quarter turn (16384 units), series in nested form
    function longint cos_quarter(input longint u);
      longint x, x2, c;
      x  = (u * QTR_TURN_Q30) >>> 14;
      x2 = (x * x) >>> 30;
      c  = ONE_Q30 - x2 / 90;
      c  = ONE_Q30 - ((x2 * c) >>> 30) / 56;
      c  = ONE_Q30 - ((x2 * c) >>> 30) / 30;
      c  = ONE_Q30 - ((x2 * c) >>> 30) / 12;
      c  = ONE_Q30 - ((x2 * c) >>> 30) / 2;
      if (c < 0) c = 0;
      if (c > ONE_Q30) c = ONE_Q30;
      return c;
    endfunction

    function logic [17:0] one_minus_cos(input logic [15:0] angle);
      logic [15:0] ph;
      longint u, c, c16;
      ph = (angle >> (16 - COS_TABLE_BITS)) << (16 - COS_TABLE_BITS);
      u = longint'(ph[13:0]);
      case (ph[15:14])
        2'd0:    c = cos_quarter(u);
        2'd1:    c = -cos_quarter(16384 - u);
        2'd2:    c = -cos_quarter(u);
        default: c = cos_quarter(16384 - u);
      endcase
      c16 = (c >= 0) ? ((c + 8192) >>> 14) : -((-c + 8192) >>> 14);
      return 18'(65536 - c16);
    endfunction

    function void phase_terms(input logic [TIME_W-1:0] t, output logic [DIST_W-1:0] quad,
                              output logic [DIST_W-1:0] cosv);
      logic [63:0] prod;
      logic [15:0] angle;
      prod  = (64'(omega) * 64'(t)) >> (16 + TIME_FRAC_BITS);
      angle = prod[15:0];
      quad  = scaled_product(64'(t) * 64'(t), half_acc, 2 * TIME_FRAC_BITS + 16);
      cosv  = scaled_product(64'(acc_omega_sq), 32'(one_minus_cos(angle)), 16);
    endfunction

    function void note_tick(input logic [INC_W-1:0] inc, input logic rs);
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] t, rem;
      logic [DIST_W-1:0] quad, cosv;
      logic [63:0]       step;
      pos_word_t         w;
      if (rs) begin
        elapsed = '0;
        distance = '0;
      end
      sum = {1'b0, elapsed} + (TIME_W+1)'(inc);
      t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      elapsed = t;
      if (t < accel_end) begin
        phase_terms(t, quad, cosv);
        distance = clamp_pos(longint'(quad) - longint'(cosv));
      end else if (t > decel_begin) begin
        rem = (duration >= t) ? duration - t : t - duration;
        phase_terms(rem, quad, cosv);
        distance = clamp_pos(longint'(length) - longint'(quad) + longint'(cosv));
      end else begin
        step = (64'(inc) * 64'(cruise)) >> TIME_FRAC_BITS;
        distance = clamp_pos(longint'(distance) + longint'(step));
      end
      w.position = distance;
      w.done = (t > duration);
      pending_positions.push_back(w);
    endfunction

    function void check_position(input logic [DIST_W-1:0] position, input logic done);
      pos_word_t w;
      if (pending_positions.size() == 0) begin
        $display("%0t: pos word with none expected: position=%h done=%b", $time, position, done);
        errors++;
      end else begin
        w = pending_positions.pop_front();
        checked++;
        if (position !== w.position) begin
          $display("%0t: position mismatch exp=%h got=%h", $time, w.position, position);
          errors++;
        end
        if (done !== w.done) begin
          $display("%0t: move_done mismatch exp=%b got=%b", $time, w.done, done);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_positions.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  spap_tick_if tick_bus();
  spap_pos_if  pos_bus();

  position_ledger ledger = new();
  bit gaps_on = 1'b1;
  int ticks_sent = 0;
  int profiles_run = 0;
  int stall_left = 0;
  int quiet = 0;

  sinusoidal_accel_path_profiler DUT (
    .clk(clk),
    .rst(rst),
    .tick(tick_bus),
    .pos(pos_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each word, stall in random bursts
  always @(posedge clk) begin
    if (!rst && pos_bus.valid && pos_bus.ready) begin
      ledger.check_position(pos_bus.path_position, pos_bus.move_done);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pos_bus.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      pos_bus.ready <= 1'b0;
    end else begin
      pos_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((tick_bus.valid && tick_bus.ready) || (pos_bus.valid && pos_bus.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("[sinusoidal_accel_path_profiler] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand32();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47);
  endfunction

  task automatic send_tick(input logic [INC_W-1:0] inc, input logic rs);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      tick_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.tick_increment <= inc;
    tick_bus.restart <= rs;
    do @(posedge clk); while (!tick_bus.ready);
    ledger.note_tick(inc, rs);
    ticks_sent++;
  endtask

  // hold the sender until every position is back and the block has settled
  task automatic wait_drain();
    tick_bus.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    ledger.set_reg(idx, val);
  endtask

  task automatic load_profile(input int mode);
    logic [31:0] ta, td, dur, ha, om, cv;
    logic [47:0] len, ao;
    len = rand48();
    ao  = rand48();
    ha  = rand32();
    om  = $urandom;
    cv  = rand32();
    case (mode)
      PROF_TYPICAL: begin
        ta  = $urandom_range(32'h0000_4000, 32'h0200_0000);
        td  = ta + $urandom_range(0, 32'h0200_0000);
        dur = td + $urandom_range(0, 32'h0200_0000);
      end
      PROF_RANDOM: begin
        ta  = $urandom;
        td  = $urandom;
        dur = $urandom;
        len = {16'($urandom), 32'($urandom)};
        ao  = {16'($urandom), 32'($urandom)};
      end
      PROF_MAX: begin
        ta  = '1;
        td  = '1;
        dur = '1;
        len = '1;
        ao  = '1;
        ha  = '1;
        om  = '1;
        cv  = '1;
      end
      default: begin
        // no accel phase, decel from the start or after a short cruise; ticks also land past the end of the move
        ta  = '0;
        td  = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom_range(0, 32'h0010_0000);
        dur = $urandom_range(0, 32'h0080_0000);
      end
    endcase
    write_reg(REG_ACCEL_END, CFG_DATA_W'(ta));
    write_reg(REG_DECEL_BEGIN, CFG_DATA_W'(td));
    write_reg(REG_MOVE_DUR, CFG_DATA_W'(dur));
    write_reg(REG_MOVE_LEN, len);
    write_reg(REG_HALF_ACCEL, CFG_DATA_W'(ha));
    write_reg(REG_ACCEL_OMEGA, ao);
    write_reg(REG_OMEGA_RATE, CFG_DATA_W'(om));
    write_reg(REG_CRUISE_VEL, CFG_DATA_W'(cv));
    cfg_we <= 1'b0;
    profiles_run++;
  endtask

  // restart, then n ticks spread to run a little past the move duration
  task automatic run_move(input int n);
    longint span, base, inc;
    span = longint'(ledger.duration) + longint'(ledger.duration) / 8 + 1;
    base = span / n;
    if (base > MAX_INC) base = MAX_INC;
    if (base < 1) base = 1;
    send_tick(INC_W'($urandom_range(0, 32'(base / 4))), 1'b1);
    for (int i = 0; i < n; i++) begin
      inc = base - base / 8 + longint'($urandom_range(0, 32'(base / 4)));
      if (inc > MAX_INC) inc = MAX_INC;
      send_tick(INC_W'(inc), 1'b0);
    end
  endtask

  initial begin
    int start;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_bus.valid = 1'b0;
    tick_bus.tick_increment = '0;
    tick_bus.restart = 1'b0;
    pos_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // all registers still zero after reset
    send_tick('0, 1'b1);
    send_tick('1, 1'b0);
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);
    wait_drain();

    // small profile walked in 4 ms steps: accel, both phase edges, cruise,
    // decel, exactly at the end, past the end
    write_reg(REG_ACCEL_END, 48'h0000_0010_0000);
    write_reg(REG_DECEL_BEGIN, 48'h0000_0030_0000);
    write_reg(REG_MOVE_DUR, 48'h0000_0040_0000);
    write_reg(REG_MOVE_LEN, 48'h0000_0800_0000);
    write_reg(REG_HALF_ACCEL, 48'h0000_0010_0000);
    write_reg(REG_ACCEL_OMEGA, 48'h0000_0040_0000);
    write_reg(REG_OMEGA_RATE, 48'h0000_0400_0000);
    write_reg(REG_CRUISE_VEL, 48'h0000_0004_0000);
    cfg_we <= 1'b0;
    profiles_run++;
    send_tick(24'h04_0000, 1'b1);
    repeat (16) send_tick(24'h04_0000, 1'b0);
    send_tick('0, 1'b1);
    send_tick('1, 1'b0);

    for (int p = 0; p < NUM_PROFILES; p++) begin
      wait_drain();
      gaps_on = (p < NUM_PROFILES - 2);
      load_profile(p % 4);
      start = ticks_sent;
      if (p == PROF_MAX) begin
        // long run with no restart drives elapsed time into saturation
        send_tick(24'h0, 1'b1);
        repeat (SAT_RUN_TICKS) send_tick(INC_W'($urandom_range(24'hF8_0000, 24'hFF_FFFF)), 1'b0);
      end
      while (ticks_sent - start < PROFILE_TICKS) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) send_tick(INC_W'($urandom), 1'($urandom));
        end else begin
          run_move($urandom_range(4, 24));
        end
      end
    end

    wait_drain();
    $display("%0d tick words over %0d register profiles, %0d positions checked",
             ticks_sent, profiles_run, ledger.checked);
    $display("phases covered: accel, cruise, decel, past end, time and distance saturation");
    if (ledger.errors == 0) begin
      $display("[sinusoidal_accel_path_profiler] OK");
    end else begin
      $display("[sinusoidal_accel_path_profiler] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/spap_pkg.sv
sv/spap_tick_if.sv
sv/spap_pos_if.sv
sv/spap_useq.sv
sv/spap_datapath.sv
sv/sinusoidal_accel_path_profiler.sv
dv/sinusoidal_accel_path_profiler_tb.sv
